// File: sv/sxl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_pkg
// Shared types, codes and the byte classifier of the S-expression lexer.
// ----------------------------------------------------------------------------
package sxl_pkg;

   localparam int OFFSET_BITS_DEF = 16;   // default offset counter width
   localparam int TOKEN_FIELD_W   = 16;   // width of offset/length on the port
   localparam int RSP_DEPTH       = 4;    // result queue entries
   localparam int RSP_PTR_W       = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W       = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_END     = 3'd0,
      KIND_LPAREN  = 3'd1,
      KIND_RPAREN  = 3'd2,
      KIND_SYMBOL  = 3'd3,
      KIND_INTEGER = 3'd4,
      KIND_BADCHAR = 3'd5,
      KIND_TOOLONG = 3'd6
   } token_kind_type;

   typedef enum logic [1:0] {
      RUN_NONE    = 2'd0,
      RUN_SYMBOL  = 2'd1,
      RUN_INTEGER = 2'd2
   } run_kind_type;

   typedef enum logic [2:0] {
      CL_SPACE,
      CL_LPAREN,
      CL_RPAREN,
      CL_DIGIT,
      CL_SYMCH,
      CL_BAD
   } byte_class_type;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_END  = 1'b1
   } req_op_type;

   typedef struct packed {
      token_kind_type             kind;
      logic [TOKEN_FIELD_W-1:0]   offset;
      logic [TOKEN_FIELD_W-1:0]   length;
      logic                       last;
   } rsp_item_type;

   // Up to two results made by one request, in order.
   typedef struct packed {
      logic [1:0]    count;
      rsp_item_type  first;
      rsp_item_type  second;
   } sxl_result_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      c = CL_BAD;
      priority if (b == 8'h20 || b == 8'h0A || b == 8'h09 || b == 8'h0D || b == 8'h0B)
         c = CL_SPACE;
      else if (b == 8'h28)
         c = CL_LPAREN;
      else if (b == 8'h29)
         c = CL_RPAREN;
      else if (b >= 8'h30 && b <= 8'h39)
         c = CL_DIGIT;
      else if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A))
         c = CL_SYMCH;
      else if (b == 8'h2B || b == 8'h2D || b == 8'h21 || b == 8'h5F || b == 8'h3A ||
               b == 8'h2F || b == 8'h7E || b == 8'h25 || b == 8'h2E || b == 8'h3C ||
               b == 8'h3E || b == 8'h3D || b == 8'h2A)
         c = CL_SYMCH;
      else
         c = CL_BAD;
      return c;
   endfunction

endpackage

// File: sv/sxl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_core
// Lexer state and token decisions: one request in, up to two results out.
// ----------------------------------------------------------------------------
module sxl_core import sxl_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic            op,
   input  logic [7:0]      text_byte,
   output sxl_result_type  res
);

   localparam logic [OFFSET_BITS-1:0] LIMIT = '1;

   run_kind_type              run_kind_ff, run_kind_in;
   logic [OFFSET_BITS-1:0]    run_start_ff, run_start_in;
   logic [OFFSET_BITS-1:0]    position_ff, position_in;
   logic                      error_hold_ff, error_hold_in;

   byte_class_type            cls;
   logic                      extend;
   logic                      close;
   logic                      run_emit;
   logic                      ev_valid;
   token_kind_type            ev_kind;
   logic                      ev_len_one;
   logic [OFFSET_BITS-1:0]    run_len;
   logic [OFFSET_BITS+TOKEN_FIELD_W-1:0] pos_wide, start_wide, len_wide;
   rsp_item_type              run_item, ev_item;

   assign cls      = classify(text_byte);
   assign run_len  = position_ff - run_start_ff;
   // zero-extend then cut to the port width, works for any OFFSET_BITS
   assign pos_wide   = {{TOKEN_FIELD_W{1'b0}}, position_ff};
   assign start_wide = {{TOKEN_FIELD_W{1'b0}}, run_start_ff};
   assign len_wide   = {{TOKEN_FIELD_W{1'b0}}, run_len};

   always_comb begin
      run_kind_in   = run_kind_ff;
      run_start_in  = run_start_ff;
      position_in   = position_ff;
      error_hold_in = error_hold_ff;
      extend        = 1'b0;
      close         = 1'b0;
      ev_valid      = 1'b0;
      ev_kind       = KIND_END;
      ev_len_one    = 1'b0;
      if (op == OP_END) begin
         close         = !error_hold_ff;
         ev_valid      = !error_hold_ff;
         ev_kind       = KIND_END;
         run_kind_in   = RUN_NONE;
         run_start_in  = '0;
         position_in   = '0;
         error_hold_in = 1'b0;
      end else if (!error_hold_ff) begin
         if (position_ff == LIMIT) begin
            close         = 1'b1;
            ev_valid      = 1'b1;
            ev_kind       = KIND_TOOLONG;
            error_hold_in = 1'b1;
            run_kind_in   = RUN_NONE;
         end else begin
            extend = (run_kind_ff == RUN_SYMBOL && (cls == CL_DIGIT || cls == CL_SYMCH)) ||
                     (run_kind_ff == RUN_INTEGER && cls == CL_DIGIT);
            if (!extend) begin
               close       = 1'b1;
               run_kind_in = RUN_NONE;
               unique case (cls)
                  CL_LPAREN: begin
                     ev_valid   = 1'b1;
                     ev_kind    = KIND_LPAREN;
                     ev_len_one = 1'b1;
                  end
                  CL_RPAREN: begin
                     ev_valid   = 1'b1;
                     ev_kind    = KIND_RPAREN;
                     ev_len_one = 1'b1;
                  end
                  CL_DIGIT: begin
                     run_kind_in  = RUN_INTEGER;
                     run_start_in = position_ff;
                  end
                  CL_SYMCH: begin
                     run_kind_in  = RUN_SYMBOL;
                     run_start_in = position_ff;
                  end
                  CL_BAD: begin
                     ev_valid      = 1'b1;
                     ev_kind       = KIND_BADCHAR;
                     error_hold_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            if (cls != CL_BAD || extend)
               position_in = position_ff + 1'b1;
         end
      end
   end

   assign run_emit = close && (run_kind_ff != RUN_NONE);

   always_comb begin
      run_item.kind   = (run_kind_ff == RUN_SYMBOL) ? KIND_SYMBOL : KIND_INTEGER;
      run_item.offset = start_wide[TOKEN_FIELD_W-1:0];
      run_item.length = len_wide[TOKEN_FIELD_W-1:0];
      run_item.last   = !ev_valid;
      ev_item.kind    = ev_kind;
      ev_item.offset  = pos_wide[TOKEN_FIELD_W-1:0];
      ev_item.length  = ev_len_one ? TOKEN_FIELD_W'(1) : '0;
      ev_item.last    = 1'b1;

      res.first  = run_emit ? run_item : ev_item;
      res.second = ev_item;
      if (!fire)
         res.count = 2'd0;
      else
         res.count = {1'b0, run_emit} + {1'b0, ev_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_kind_ff   <= RUN_NONE;
         run_start_ff  <= '0;
         position_ff   <= '0;
         error_hold_ff <= 1'b0;
      end else if (fire) begin
         run_kind_ff   <= run_kind_in;
         run_start_ff  <= run_start_in;
         position_ff   <= position_in;
         error_hold_ff <= error_hold_in;
      end
   end

endmodule

// File: sv/sxl_rsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_rsp_queue
// Small result queue: takes zero, one or two results a cycle, gives one when the consumer is ready.
// ----------------------------------------------------------------------------
module sxl_rsp_queue import sxl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  sxl_result_type  push,
   output logic            room,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_item_type    out_item
);

   rsp_item_type              entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]      count_ff, count_in;
   logic                      pop;
   logic [RSP_PTR_W-1:0]      wr_next;

   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // room for two results whatever the consumer does this cycle
   assign room      = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0)
         entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2)
         entry_ff[wr_next] <= push.second;
   end

endmodule

// File: sv/sexpr_token_lexer.sv
`timescale 1ns / 1ps
// Results of an accepted request are registered in the queue that drives rsp_.
// One request per cycle while req_tready is high; a request that closes a run
// and emits a second token gives two results, so a 4-entry result queue sets
// the rate: req_tready drops while it holds more than two results.
// Reset (synchronous, active high) empties the queue and returns the lexer to
// offset 0 with no run open and no error pending.
// ----------------------------------------------------------------------------
// sexpr_token_lexer
// Streaming S-expression tokenizer: bytes in, tokens with offset and length out.
// ----------------------------------------------------------------------------
module sexpr_token_lexer import sxl_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,

   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] text_byte
   input  logic         req_tuser,    // [0] op: 0 text byte, 1 end of text

   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,    // [15:0] token_offset, [31:16] token_length
   output logic [2:0]   rsp_tuser,    // [2:0] token_kind
   output logic         rsp_tlast     // last_of_item
);

   logic            req_fire;
   sxl_result_type  core_res;
   rsp_item_type    head;

   // A request is taken only when the queue can absorb both possible results.
   assign req_fire = req_tvalid && req_tready;

   // Classification, run tracking and token assembly all happen in the
   // cycle of acceptance; the queue registers the outcome.
   sxl_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .op        (req_tuser),
      .text_byte (req_tdata),
      .res       (core_res)
   );

   sxl_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (core_res),
      .room      (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {head.length, head.offset};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
